// File: rtl/core/hufd_pkg.sv
// Shared constants, codes and control structs of the table-driven Huffman decoder.
`default_nettype none

package hufd_pkg;

    // Default sizes
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int MAX_CODE_LEN_DEF = 16;

    // Payload widths
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int SYM_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = CODE_W + LEN_W + SYM_W;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

    // End-of-message symbol, first bit taken from a byte
    localparam logic [SYM_W-1:0] EOM_SYMBOL = '0;
    localparam logic [2:0]       TOP_BIT    = 3'd7;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_entry;
        logic start_msg;
        logic take_byte;
        logic shift_bit;
        logic scan_first;
        logic scan_read;
        logic scan_next;
        logic take_hit;
        logic take_err;
        logic next_bit;
        logic put_new;
        logic put_push;
        logic flush;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_last;
        logic cnt_full;
        logic bit_last;
        logic msg_done;
        logic pend_v;
        logic out_free;
        logic new_eom;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/hufd_if.sv
// Input and result channel interfaces of the Huffman decoder.
`default_nettype none

interface hufd_in_if import hufd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    entry_index;
    logic [CODE_W-1:0]   code_value;
    logic [LEN_W-1:0]    code_length;
    logic [SYM_W-1:0]    entry_symbol;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, action, entry_index, code_value, code_length,
                    entry_symbol, data_byte, input ready);
    modport sink   (input valid, action, entry_index, code_value, code_length,
                    entry_symbol, data_byte, output ready);
endinterface

interface hufd_out_if import hufd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             end_of_message;
    logic             code_error;
    logic             last;

    modport source (output valid, symbol, end_of_message, code_error, last, input ready);
    modport sink   (input valid, symbol, end_of_message, code_error, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hufd_ctrl.sv
// Sequencer of the Huffman decoder: bit stepping, table scan and result hand-off.
`default_nettype none

module hufd_ctrl
    import hufd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hufd_in_if.sink   i_in,
    input  t_stat     i_stat,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_READ,
        ST_CMP,
        ST_PUT,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign i_in.ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    priority if (i_in.action == ACT_LOAD) begin
                        o_cmd.load_entry = 1'b1;
                    end else if (i_in.action == ACT_START) begin
                        o_cmd.start_msg = 1'b1;
                    end else if (i_in.action == ACT_DATA && !i_stat.msg_done) begin
                        o_cmd.take_byte = 1'b1;
                        n_state         = ST_SHIFT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.shift_bit  = 1'b1;
                o_cmd.scan_first = 1'b1;
                n_state          = ST_READ;
            end
            ST_READ: begin
                o_cmd.scan_read = 1'b1;
                n_state         = ST_CMP;
            end
            ST_CMP: begin
                priority if (i_stat.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_PUT;
                end else if (!i_stat.scan_last) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = ST_READ;
                end else if (i_stat.cnt_full) begin
                    o_cmd.take_err = 1'b1;
                    n_state        = ST_PUT;
                end else if (i_stat.bit_last) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.next_bit = 1'b1;
                    n_state        = ST_SHIFT;
                end
            end
            ST_PUT: begin
                // a held result goes out with last clear once a newer one exists
                if (!i_stat.pend_v || i_stat.out_free) begin
                    o_cmd.put_new  = !i_stat.pend_v;
                    o_cmd.put_push = i_stat.pend_v;
                    if (i_stat.new_eom || i_stat.bit_last) begin
                        n_state = ST_FIN;
                    end else begin
                        o_cmd.next_bit = 1'b1;
                        n_state        = ST_SHIFT;
                    end
                end
            end
            ST_FIN: begin
                if (!i_stat.pend_v) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/hufd_dp.sv
// Datapath of the Huffman decoder: code table, bit buffer, match logic, result registers.
`default_nettype none

module hufd_dp
    import hufd_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hufd_in_if.sink    i_in,
    hufd_out_if.source o_out,
    input  t_cmd       i_cmd,
    output t_stat      o_stat
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(MAX_CODE_LEN + 1);
    localparam int LW   = (CW > LEN_W) ? CW : LEN_W;
    localparam int CMPW = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [IDX_W:0]  DEPTH_LIM = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0]   CNT_MAX   = CW'(MAX_CODE_LEN);

    // Code table and its used bits
    logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_used;
    logic [ENTRY_W-1:0]     r_rd;
    logic                   r_rd_used;
    logic [AW-1:0]          r_addr;

    logic                   wr_ok;
    logic [AW-1:0]          wr_addr;

    // Bit buffer and byte stepping
    logic [MAX_CODE_LEN-1:0] r_buf;
    logic [CW-1:0]           r_cnt;
    logic [BYTE_W-1:0]       r_byte;
    logic [2:0]              r_bidx;
    logic                    r_msg_done;

    // New, held and output result
    logic [SYM_W-1:0] r_new_sym;
    logic             r_new_eom;
    logic             r_new_err;
    logic [SYM_W-1:0] r_pend_sym;
    logic             r_pend_eom;
    logic             r_pend_err;
    logic             r_pend_v;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_out_eom;
    logic             r_out_err;
    logic             r_out_last;
    logic             r_out_valid;

    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    logic [SYM_W-1:0]  rd_sym;
    logic [CMPW-1:0]   len_mask;
    logic              hit;
    logic              out_free;

    assign wr_ok   = ({1'b0, i_in.entry_index} < DEPTH_LIM);
    assign wr_addr = i_in.entry_index[AW-1:0];

    // Table write and scan read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_entry && wr_ok) begin
            mem[wr_addr] <= {i_in.code_value, i_in.code_length, i_in.entry_symbol};
        end
        if (i_cmd.scan_read) begin
            r_rd <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
            r_addr    <= '0;
        end else begin
            if (i_cmd.load_entry && wr_ok) begin
                r_used[wr_addr] <= 1'b1;
            end
            if (i_cmd.scan_read) begin
                r_rd_used <= r_used[r_addr];
            end
            if (i_cmd.scan_first) begin
                r_addr <= '0;
            end else if (i_cmd.scan_next) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // Match of the read entry against the buffer
    assign rd_code = r_rd[ENTRY_W-1 -: CODE_W];
    assign rd_len  = r_rd[SYM_W +: LEN_W];
    assign rd_sym  = r_rd[SYM_W-1:0];

    always_comb begin
        for (int i = 0; i < CMPW; i++) begin
            len_mask[i] = (i < int'(rd_len));
        end
    end

    assign hit = r_rd_used && (rd_len != '0) && (LW'(rd_len) == LW'(r_cnt))
              && ((CMPW'(rd_code) & len_mask) == CMPW'(r_buf));

    assign out_free = !r_out_valid || o_out.ready;

    // Buffer, byte and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf      <= '0;
            r_cnt      <= '0;
            r_msg_done <= 1'b0;
        end else begin
            if (i_cmd.start_msg || i_cmd.take_hit || i_cmd.take_err) begin
                r_buf <= '0;
                r_cnt <= '0;
            end else if (i_cmd.shift_bit) begin
                r_buf <= {r_buf[MAX_CODE_LEN-2:0], r_byte[r_bidx]};
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.start_msg) begin
                r_msg_done <= 1'b0;
            end else if (i_cmd.take_hit && rd_sym == EOM_SYMBOL) begin
                r_msg_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_byte <= i_in.data_byte;
            r_bidx <= TOP_BIT;
        end else if (i_cmd.next_bit) begin
            r_bidx <= r_bidx - 1'b1;
        end
        if (i_cmd.take_hit) begin
            r_new_sym <= rd_sym;
            r_new_eom <= (rd_sym == EOM_SYMBOL);
            r_new_err <= 1'b0;
        end else if (i_cmd.take_err) begin
            r_new_sym <= '0;
            r_new_eom <= 1'b0;
            r_new_err <= 1'b1;
        end
        if (i_cmd.put_new || i_cmd.put_push) begin
            r_pend_sym <= r_new_sym;
            r_pend_eom <= r_new_eom;
            r_pend_err <= r_new_err;
        end
        if (i_cmd.put_push || i_cmd.flush) begin
            r_out_sym  <= r_pend_sym;
            r_out_eom  <= r_pend_eom;
            r_out_err  <= r_pend_err;
            r_out_last <= i_cmd.flush;
        end
    end

    // Held and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.put_new) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.put_push || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.symbol         = r_out_sym;
    assign o_out.end_of_message = r_out_eom;
    assign o_out.code_error     = r_out_err;
    assign o_out.last           = r_out_last;

    assign o_stat.hit       = hit;
    assign o_stat.scan_last = (r_addr == LAST_ADDR);
    assign o_stat.cnt_full  = (r_cnt >= CNT_MAX);
    assign o_stat.bit_last  = (r_bidx == '0);
    assign o_stat.msg_done  = r_msg_done;
    assign o_stat.pend_v    = r_pend_v;
    assign o_stat.out_free  = out_free;
    assign o_stat.new_eom   = r_new_eom;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("bit count beyond maximum code length");
    a_no_shift_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_bit |-> !r_msg_done)
        else $error("bit decoded after end of message");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put_push || i_cmd.flush) |-> (r_pend_v && out_free))
        else $error("result pushed without a held item or output room");
    a_eom_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_hit && rd_sym == EOM_SYMBOL) |=> r_msg_done)
        else $error("end code did not close the message");
`endif

endmodule

`default_nettype wire

// File: rtl/core/huffman_table_decoder.sv
// Huffman table decoder: channels, controller and datapath.
//
// Usage: items enter on i_in (valid/ready). Action load writes one code table
// slot, action start clears the bit buffer and the end-of-message flag. A data
// item feeds eight bits, most significant first, up to an end-of-message code;
// data after the end of a message is dropped until the next start. For each bit
// the block scans the table slot by slot (registered table read then compare)
// through its single table read port, stopping at the first match.
// One item is in work at a time; i_in.ready is high when the block is idle.
// Results leave on o_out from an output register; the last result of a byte is
// held back until the byte ends so its last flag is known. A stalled receiver
// holds the result steady and the block waits only when a second result needs
// the output register. Reset empties the table (all slots unused), clears the
// buffer and the end flag and drops any result in flight.
`default_nettype none

module huffman_table_decoder
    import hufd_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hufd_in_if.sink    i_in,
    hufd_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    hufd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    hufd_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

`default_nettype wire
